// ===== rtl/dsc_pkg.sv =====
package dsc_pkg;

  localparam int DEF_MAX_PATTERN = 64;
  localparam int DEF_COUNT_BITS  = 32;
  localparam int SYM_W           = 8;
  localparam int OP_W            = 2;
  localparam int OUT_COUNT_W     = 32;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TEXT   = 2'd2
  } dsc_op_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             fire;
    dsc_op_t          op;
    logic [SYM_W-1:0] sym;
  } dsc_cmd_t;

endpackage

// ===== rtl/dsc_in_if.sv =====
interface dsc_in_if import dsc_pkg::*;;
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [SYM_W-1:0] symbol;

  modport source (output valid, output opcode, output symbol, input ready);
  modport sink   (input valid, input opcode, input symbol, output ready);
endinterface

// ===== rtl/dsc_out_if.sv =====
interface dsc_out_if import dsc_pkg::*;;
  logic                   valid;
  logic                   ready;
  logic [OUT_COUNT_W-1:0] count;
  logic                   saturated;
  logic                   rejected;

  modport source (output valid, output count, output saturated, output rejected,
                  input ready);
  modport sink   (input valid, input count, input saturated, input rejected,
                  output ready);
endinterface

// ===== rtl/dsc_cell.sv =====
module dsc_cell import dsc_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dsc_cmd_t              cmd,
  input  logic                  prev_valid,
  input  logic [COUNT_BITS-1:0] prev_count,
  output logic                  valid_o,
  output logic [COUNT_BITS-1:0] count_o,
  output logic                  sat_o
);

  logic                  valid_r, valid_nxt;
  logic [SYM_W-1:0]      sym_r, sym_nxt;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [COUNT_BITS:0]   sum;
  logic                  hit;

  assign hit = cmd.fire && (cmd.op == OP_TEXT) && valid_r && (sym_r == cmd.sym);
  assign sum = {1'b0, count_r} + {1'b0, prev_count};

  always_comb begin
    valid_nxt = valid_r;
    sym_nxt   = sym_r;
    count_nxt = count_r;
    if (cmd.fire) begin
      case (cmd.op)
        OP_CLEAR: begin
          valid_nxt = 1'b0;
        end
        OP_APPEND: begin
          // first free slot of the chain takes the symbol
          if (!valid_r && prev_valid) begin
            valid_nxt = 1'b1;
            sym_nxt   = cmd.sym;
            count_nxt = '0;
          end
        end
        OP_TEXT: begin
          if (hit) begin
            count_nxt = sum[COUNT_BITS] ? {COUNT_BITS{1'b1}} : sum[COUNT_BITS-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    count_r <= count_nxt;
  end

  assign valid_o = valid_r;
  assign count_o = count_r;
  assign sat_o   = hit && sum[COUNT_BITS];

endmodule

// ===== rtl/distinct_subsequence_counter_unit.sv =====
// Distinct subsequence counter.
// Input channel in_chan carries one transaction per item: opcode (clear,
// append pattern symbol, text symbol) and an 8-bit symbol. Output channel
// out_chan returns one transaction per item: the count of distinct
// occurrences of the whole pattern in the text since the last clear
// (1 for an empty pattern), the sticky saturation flag and a reject bit
// for an append that found the pattern store full.
// The pattern lives in a chain of MAX_PATTERN cells, one per position; each
// cell keeps its symbol and its prefix count and adds its left neighbor's
// count when a text symbol matches, so all positions update in the same cycle.
// Pipeline: the cells update and the pending stage is set at the accepting
// edge; the last cell's count then loads the output register once that
// register advances.
// Throughput: one item per cycle while out_chan is ready; the cell chain
// takes every item at its accepting edge.
// Stall: with a result waiting in the output register and one more item
// held in the pending stage, in_chan.ready drops until out_chan takes the
// waiting result; nothing is lost or repeated.
// Reset (rst_n low, synchronous): all cells empty (their counts are not
// reset), saturation flag low, no result pending.
module distinct_subsequence_counter_unit import dsc_pkg::*; #(
  parameter int MAX_PATTERN = DEF_MAX_PATTERN,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input logic       clk,
  input logic       rst_n,
  dsc_in_if.sink    in_chan,
  dsc_out_if.source out_chan
);

  dsc_cmd_t              cmd;
  logic                  fire;
  logic                  adv;
  logic                  rej;

  logic [MAX_PATTERN-1:0] valid_w;
  logic [MAX_PATTERN-1:0] last_w;
  logic [MAX_PATTERN-1:0] sat_w;
  logic [COUNT_BITS-1:0]  count_w [MAX_PATTERN];
  logic [COUNT_BITS-1:0]  whole;

  logic                   sat_r, sat_nxt;
  logic                   pend_r, pend_nxt;
  logic                   pend_rej_r;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r;
  logic                   out_sat_r;
  logic                   out_rej_r;

  // Handshake: the output register moves whenever it is empty or being taken.
  assign adv           = !out_valid_r || out_chan.ready;
  assign in_chan.ready = !pend_r || adv;
  assign fire          = in_chan.valid && in_chan.ready;

  assign cmd.fire = fire;
  assign cmd.op   = dsc_op_t'(in_chan.opcode);
  assign cmd.sym  = in_chan.symbol;

  // A full chain rejects the append.
  assign rej = (cmd.op == OP_APPEND) && valid_w[MAX_PATTERN-1];

  // Cell chain: each cell sees its left neighbor's state; the head sees
  // the empty prefix, which is always present and counts one.
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
    logic                  pv;
    logic [COUNT_BITS-1:0] pc;
    if (j == 0) begin : g_head
      assign pv = 1'b1;
      assign pc = COUNT_BITS'(1);
    end else begin : g_link
      assign pv = valid_w[j-1];
      assign pc = count_w[j-1];
    end

    dsc_cell #(.COUNT_BITS(COUNT_BITS)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .prev_valid (pv),
      .prev_count (pc),
      .valid_o    (valid_w[j]),
      .count_o    (count_w[j]),
      .sat_o      (sat_w[j])
    );

    // last occupied cell holds the whole-pattern count
    if (j == MAX_PATTERN - 1) begin : g_tail
      assign last_w[j] = valid_w[j];
    end else begin : g_mid
      assign last_w[j] = valid_w[j] && !valid_w[j+1];
    end
  end

  // One-hot select of the last cell's count; empty pattern reads one.
  always_comb begin
    whole = '0;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      whole = whole | ({COUNT_BITS{last_w[j]}} & count_w[j]);
    end
    if (!valid_w[0]) begin
      whole = COUNT_BITS'(1);
    end
  end

  // Sticky saturation: drop on clear, collect clamps from any cell.
  always_comb begin
    sat_nxt = sat_r | (|sat_w);
    if (fire && (cmd.op == OP_CLEAR)) begin
      sat_nxt = 1'b0;
    end
  end

  always_comb begin
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = pend_r;
      pend_nxt      = 1'b0;
    end
    if (fire) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_r       <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sat_r       <= sat_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold the pending reject bit, load the result when advancing.
  always_ff @(posedge clk) begin
    if (fire) begin
      pend_rej_r <= rej;
    end
    if (adv && pend_r) begin
      out_count_r <= OUT_COUNT_W'(whole);
      out_sat_r   <= sat_r;
      out_rej_r   <= pend_rej_r;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.count     = out_count_r;
  assign out_chan.saturated = out_sat_r;
  assign out_chan.rejected  = out_rej_r;

endmodule

// ===== rtl/dsc_checker.sv =====
module dsc_checker import dsc_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [OUT_COUNT_W-1:0] out_count,
  input logic                   out_saturated,
  input logic                   out_rejected
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({out_count, out_saturated, out_rejected}))
    else $error("result changed while stalled");

  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_valid) && out_valid |-> $past(in_valid && in_ready, 2))
    else $error("result without a preceding transaction");

endmodule

bind distinct_subsequence_counter_unit dsc_checker u_dsc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_chan.valid),
  .in_ready      (in_chan.ready),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_count     (out_chan.count),
  .out_saturated (out_chan.saturated),
  .out_rejected  (out_chan.rejected)
);
